// ----- sv/hrl_pkg.sv -----
// Shared types and constants for the hex record loader.
`timescale 1ns / 1ps

package hrl_pkg;

  localparam int ADDR_WIDTH_DEF = 16;
  localparam int CHAR_WIDTH     = 8;
  localparam int OUT_ADDR_WIDTH = 16;
  localparam int DATA_WIDTH     = 8;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_F   = 8'h66;
  localparam logic [7:0] LOW_A_OFFSET = 8'h57;
  localparam logic [7:0] UP_A_OFFSET  = 8'h37;
  localparam logic [7:0] TYPE_EOF     = 8'h01;

  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_END       = 2'd1,
    KIND_BAD_START = 2'd2,
    KIND_BAD_SUM   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic [OUT_ADDR_WIDTH-1:0]   address;
    logic [DATA_WIDTH-1:0]       data;
  } result_t;

endpackage

// ----- sv/hrl_parser.sv -----
// Record parser: phase tracking, digit decoding, checksum and address counting.
`timescale 1ns / 1ps

module hrl_parser #(
  parameter int ADDR_WIDTH = hrl_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [hrl_pkg::CHAR_WIDTH-1:0]      char_in,
  output logic                                res_valid,
  output hrl_pkg::result_t                    res
);

  typedef enum logic [3:0] {
    PH_AWAIT   = 4'd0,
    PH_COUNT   = 4'd1,
    PH_ADDR_HI = 4'd2,
    PH_ADDR_LO = 4'd3,
    PH_TYPE    = 4'd4,
    PH_DATA    = 4'd5,
    PH_CHECK   = 4'd6,
    PH_SKIP    = 4'd7,
    PH_HALT    = 4'd8
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [3:0]              high_nibble_r, high_nibble_nxt;
  logic                    digit_half_r, digit_half_nxt;
  logic [7:0]              bytes_left_r, bytes_left_nxt;
  logic [ADDR_WIDTH-1:0]   cur_address_r, cur_address_nxt;
  logic [7:0]              record_type_r, record_type_nxt;
  logic [7:0]              running_sum_r, running_sum_nxt;

  logic [7:0] digit;
  logic [7:0] byte_val;
  logic [7:0] sum_upd;

  always_comb begin
    if (char_in >= hrl_pkg::CHAR_ZERO && char_in <= hrl_pkg::CHAR_NINE) begin
      digit = char_in - hrl_pkg::CHAR_ZERO;
    end else if (char_in >= hrl_pkg::CHAR_LOW_A && char_in <= hrl_pkg::CHAR_LOW_F) begin
      digit = char_in - hrl_pkg::LOW_A_OFFSET;
    end else begin
      digit = char_in - hrl_pkg::UP_A_OFFSET;
    end
  end

  assign byte_val = {high_nibble_r, 4'h0} + digit;
  assign sum_upd  = running_sum_r + byte_val;

  always_comb begin
    phase_nxt       = phase_r;
    high_nibble_nxt = high_nibble_r;
    digit_half_nxt  = digit_half_r;
    bytes_left_nxt  = bytes_left_r;
    cur_address_nxt = cur_address_r;
    record_type_nxt = record_type_r;
    running_sum_nxt = running_sum_r;
    res_valid       = 1'b0;
    res.kind        = hrl_pkg::KIND_WRITE;
    res.address     = '0;
    res.data        = '0;
    if (step) begin
      unique case (phase_r)
        PH_AWAIT: begin
          if (char_in == hrl_pkg::CHAR_COLON) begin
            running_sum_nxt = '0;
            digit_half_nxt  = 1'b0;
            phase_nxt       = PH_COUNT;
          end else begin
            res_valid = 1'b1;
            res.kind  = hrl_pkg::KIND_BAD_START;
            phase_nxt = PH_HALT;
          end
        end
        PH_SKIP: begin
          if (char_in == hrl_pkg::CHAR_NEWLINE) begin
            phase_nxt = PH_AWAIT;
          end
        end
        PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA, PH_CHECK: begin
          if (!digit_half_r) begin
            high_nibble_nxt = digit[3:0];
            digit_half_nxt  = 1'b1;
          end else begin
            digit_half_nxt  = 1'b0;
            running_sum_nxt = sum_upd;
            unique case (phase_r)
              PH_COUNT: begin
                bytes_left_nxt = byte_val;
                phase_nxt      = PH_ADDR_HI;
              end
              PH_ADDR_HI: begin
                cur_address_nxt = ADDR_WIDTH'({byte_val, 8'h00});
                phase_nxt       = PH_ADDR_LO;
              end
              PH_ADDR_LO: begin
                cur_address_nxt = cur_address_r | ADDR_WIDTH'(byte_val);
                phase_nxt       = PH_TYPE;
              end
              PH_TYPE: begin
                record_type_nxt = byte_val;
                phase_nxt       = (bytes_left_r != 8'h00) ? PH_DATA : PH_CHECK;
              end
              PH_DATA: begin
                res_valid       = 1'b1;
                res.kind        = hrl_pkg::KIND_WRITE;
                res.address     = cur_address_r[hrl_pkg::OUT_ADDR_WIDTH-1:0];
                res.data        = byte_val;
                cur_address_nxt = cur_address_r + ADDR_WIDTH'(1);
                bytes_left_nxt  = bytes_left_r - 8'h01;
                if (bytes_left_r == 8'h01) begin
                  phase_nxt = PH_CHECK;
                end
              end
              default: begin
                if (sum_upd != 8'h00) begin
                  res_valid = 1'b1;
                  res.kind  = hrl_pkg::KIND_BAD_SUM;
                  phase_nxt = PH_HALT;
                end else if (record_type_r == hrl_pkg::TYPE_EOF) begin
                  res_valid   = 1'b1;
                  res.kind    = hrl_pkg::KIND_END;
                  res.address = cur_address_r[hrl_pkg::OUT_ADDR_WIDTH-1:0];
                  phase_nxt   = PH_HALT;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
            endcase
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_AWAIT;
      high_nibble_r <= '0;
      digit_half_r  <= 1'b0;
      bytes_left_r  <= '0;
      cur_address_r <= '0;
      record_type_r <= '0;
      running_sum_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      high_nibble_r <= high_nibble_nxt;
      digit_half_r  <= digit_half_nxt;
      bytes_left_r  <= bytes_left_nxt;
      cur_address_r <= cur_address_nxt;
      record_type_r <= record_type_nxt;
      running_sum_r <= running_sum_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |=> phase_r == PH_HALT)
    else $error("parser left the halted phase");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |-> !res_valid)
    else $error("result produced while halted");

  a_write_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == hrl_pkg::KIND_WRITE |-> phase_r == PH_DATA && digit_half_r)
    else $error("memory write outside the data field");

  a_report_halts: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind != hrl_pkg::KIND_WRITE |=> phase_r == PH_HALT)
    else $error("report did not halt the parser");
`endif

endmodule

// ----- sv/hrl_out_reg.sv -----
// Result register holding one beat for the output stream.
`timescale 1ns / 1ps

module hrl_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hrl_pkg::result_t  res,
  input  logic              take,
  output logic              free,
  output logic              valid,
  output hrl_pkg::result_t  res_q
);

  logic             valid_r, valid_nxt;
  hrl_pkg::result_t res_r;

  assign free = !valid_r || take;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign valid = valid_r;
  assign res_q = res_r;

endmodule

// ----- sv/hex_record_loader.sv -----
// Top level of the hex record loader: input register, parser and result register.
// A result passes the input register, the parser and then the result register.
// Throughput: one character per cycle when the output side keeps taking beats.
// A character that causes no result only passes through the input register.
// Reset (synchronous, active low) clears both stage valid flags and the parser
// state, which then waits for a colon at the start of a line.
`timescale 1ns / 1ps

module hex_record_loader #(
  parameter int ADDR_WIDTH = hrl_pkg::ADDR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] address, [23:16] data
  output logic [1:0]  out_tuser   // [1:0] kind
);

  logic                               in_v_r, in_v_nxt;
  logic [hrl_pkg::CHAR_WIDTH-1:0]     in_char_r;
  logic                               step;
  logic                               free;
  logic                               res_valid;
  hrl_pkg::result_t                   res;
  hrl_pkg::result_t                   res_q;

  assign step      = in_v_r && free;
  assign in_tready = !in_v_r || step;

  always_comb begin
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (step) begin
      in_v_nxt = 1'b0;
    end else begin
      in_v_nxt = in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
    end
  end

  hrl_parser #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .char_in   (in_char_r),
    .res_valid (res_valid),
    .res       (res)
  );

  hrl_out_reg u_out_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (res_valid),
    .res   (res),
    .take  (out_tready),
    .free  (free),
    .valid (out_tvalid),
    .res_q (res_q)
  );

  assign out_tdata = {res_q.data, res_q.address};
  assign out_tuser = res_q.kind;

endmodule
